[design/tlbat_pkg.sv]
// tlbat_pkg: shared constants and codes for the tlb address translator
// holds widths, register indexes, request function codes and reset values
// no dependencies
`default_nettype none

package tlbat_pkg;

   // tlb geometry
   localparam int TLB_DEPTH = 16;
   localparam int IDX_W     = $clog2(TLB_DEPTH);
   localparam int CNT_W     = $clog2(TLB_DEPTH + 1);

   // field widths
   localparam int ADDR_W   = 32;
   localparam int FRAME_W  = 16;
   localparam int PSIZE_W  = 17;
   localparam int EPT_W    = 11;
   localparam int SIZE_W   = 5;
   localparam int SECOND_W = 10;
   localparam int OFFSET_W = 16;
   localparam int STEP_W   = $clog2(ADDR_W);

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = PSIZE_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CFG_PAGE_SIZE      = 2'd0,
      CFG_ENTRIES_PER_TBL = 2'd1,
      CFG_TLB_SIZE       = 2'd2,
      CFG_REPLACE_POLICY = 2'd3
   } cfg_index_type;

   // request function codes
   localparam logic FUNC_TRANSLATE = 1'b0;
   localparam logic FUNC_FILL      = 1'b1;

   // replacement policy codes
   localparam logic POLICY_FIFO = 1'b0;
   localparam logic POLICY_LRU  = 1'b1;

   // register reset values
   localparam logic [PSIZE_W-1:0] PAGE_SIZE_RESET = PSIZE_W'(64);
   localparam logic [EPT_W-1:0]   EPT_RESET       = EPT_W'(4);
   localparam logic [SIZE_W-1:0]  TLB_SIZE_RESET  = SIZE_W'(4);

   // register limits
   localparam logic [PSIZE_W-1:0] PAGE_SIZE_MAX = PSIZE_W'(65536);
   localparam logic [EPT_W-1:0]   EPT_MAX       = EPT_W'(1024);
   localparam logic [SIZE_W-1:0]  TLB_SIZE_MAX  = SIZE_W'(TLB_DEPTH);

endpackage

`default_nettype wire

[design/tlb_address_translation.sv]
// tlb_address_translation: two-level paged address translator with an ordered tlb
// one sequencer around a shared bit-serial divider, a tag/frame store and a multiplier
// depends on tlbat_pkg
//
// Usage: a request (req_func, req_logical_address, req_fill_frame) is taken at
// a rising edge with start high and busy low. busy stays high until the result
// has been shown. Translate (func 0) splits the address by page_size into page
// and offset, the page by entries_per_table into first and second level
// entries, then searches the tlb oldest first; a hit gives the frame and
// frame*page_size+offset, and under lru moves the entry to the newest place.
// Fill (func 1) appends a page/frame mapping, evicting the oldest entry once
// tlb_size entries are held, and reports the eviction on rsp_replaced.
// The result is on the rsp_ ports for exactly one cycle, marked by rsp_valid;
// the receiver cannot stall it. Configuration is written through csr_write_en,
// csr_index and csr_wdata; the user must write it only while the block is idle,
// as the block itself does not enforce this. The shared divider gives one
// quotient bit per cycle over two divisions, then the search steps through the
// tlb entries one per cycle, a hit passes through the multiply state, the shift
// state moves entries one per cycle and drops one, the append state writes the
// newest entry and the done state shows the result. busy drops in the cycle
// after the result, so requests are taken one at a time.
// Reset clears the entry count and loads the register defaults; no clearing
// pass over the store is needed.
`default_nettype none

module tlb_address_translation
   import tlbat_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic                  req_func,
   input  wire logic [ADDR_W-1:0]     req_logical_address,
   input  wire logic [FRAME_W-1:0]    req_fill_frame,
   // result channel
   output logic                       rsp_valid,
   output logic                       rsp_hit,
   output logic [FRAME_W-1:0]         rsp_frame_out,
   output logic [ADDR_W-1:0]          rsp_physical_address,
   output logic [ADDR_W-1:0]          rsp_first_level_entry,
   output logic [SECOND_W-1:0]        rsp_second_level_entry,
   output logic [OFFSET_W-1:0]        rsp_page_offset,
   output logic                       rsp_replaced,
   // configuration port
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [7:0] {
      ST_IDLE      = 8'b0000_0001,
      ST_DIV_PAGE  = 8'b0000_0010,
      ST_DIV_LEVEL = 8'b0000_0100,
      ST_SEARCH    = 8'b0000_1000,
      ST_MULT      = 8'b0001_0000,
      ST_SHIFT     = 8'b0010_0000,
      ST_APPEND    = 8'b0100_0000,
      ST_DONE      = 8'b1000_0000
   } state_type;

   // control state
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [STEP_W-1:0]  step_ff, step_in;

   // configuration registers
   logic [PSIZE_W-1:0] page_size_ff, page_size_in;
   logic [EPT_W-1:0]   ept_ff, ept_in;
   logic [SIZE_W-1:0]  tlb_size_ff, tlb_size_in;
   logic               policy_ff, policy_in;

   // request and result payload
   logic                func_ff, func_in;
   logic [FRAME_W-1:0]  fill_frame_ff, fill_frame_in;
   logic [ADDR_W-1:0]   page_ff, page_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [ADDR_W-1:0]   first_ff, first_in;
   logic [SECOND_W-1:0] second_ff, second_in;
   logic                hit_ff, hit_in;
   logic [FRAME_W-1:0]  frame_ff, frame_in;
   logic [ADDR_W-1:0]   phys_ff, phys_in;
   logic                repl_ff, repl_in;

   // shared divider
   logic [ADDR_W-1:0]   div_quot_ff, div_quot_in;
   logic [PSIZE_W-1:0]  div_rem_ff, div_rem_in;
   logic [PSIZE_W-1:0]  div_divisor_ff, div_divisor_in;
   logic [PSIZE_W:0]    div_trial;
   logic [PSIZE_W+1:0]  div_diff;
   logic                div_fits;
   logic [ADDR_W-1:0]   div_quot_next;
   logic [PSIZE_W-1:0]  div_rem_next;
   logic                div_last;

   // tag and frame store
   logic [ADDR_W-1:0]   tag_mem   [TLB_DEPTH];
   logic [FRAME_W-1:0]  frame_mem [TLB_DEPTH];
   logic [ADDR_W-1:0]   rd_tag_ff;
   logic [FRAME_W-1:0]  rd_frame_ff;
   logic [IDX_W-1:0]    rd_addr;
   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr;
   logic [ADDR_W-1:0]   mem_wtag;
   logic [FRAME_W-1:0]  mem_wframe;

   // effective register values
   logic [PSIZE_W-1:0]  ps_eff;
   logic [EPT_W-1:0]    ept_eff;
   logic [SIZE_W-1:0]   size_eff;
   logic [ADDR_W-1:0]   mult_prod;
   logic                is_last_entry;
   logic                can_move;

   // clamp configured values into their working ranges
   always_comb begin
      if (page_size_ff == '0) begin
         ps_eff = PSIZE_W'(1);
      end else if (page_size_ff > PAGE_SIZE_MAX) begin
         ps_eff = PAGE_SIZE_MAX;
      end else begin
         ps_eff = page_size_ff;
      end
      if (ept_ff == '0) begin
         ept_eff = EPT_W'(1);
      end else if (ept_ff > EPT_MAX) begin
         ept_eff = EPT_MAX;
      end else begin
         ept_eff = ept_ff;
      end
      if (tlb_size_ff == '0) begin
         size_eff = SIZE_W'(1);
      end else if (tlb_size_ff > TLB_SIZE_MAX) begin
         size_eff = TLB_SIZE_MAX;
      end else begin
         size_eff = tlb_size_ff;
      end
   end

   // one restoring division step: one quotient bit per cycle
   assign div_trial     = {div_rem_ff, div_quot_ff[ADDR_W-1]};
   assign div_diff      = {1'b0, div_trial} - {2'b00, div_divisor_ff};
   assign div_fits      = ~div_diff[PSIZE_W+1];
   assign div_quot_next = {div_quot_ff[ADDR_W-2:0], div_fits};
   assign div_rem_next  = div_fits ? div_diff[PSIZE_W-1:0] : div_trial[PSIZE_W-1:0];
   assign div_last      = (step_ff == STEP_W'(ADDR_W - 1));

   // frame times page size, which always fits in the address width
   assign mult_prod = ADDR_W'(frame_ff) * ADDR_W'(ps_eff);

   // entry position checks
   assign is_last_entry = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   assign can_move      = ((CNT_W'(idx_ff) + CNT_W'(1)) < count_ff);

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

   // sequencer and datapath next values
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      step_in        = step_ff;
      page_size_in   = page_size_ff;
      ept_in         = ept_ff;
      tlb_size_in    = tlb_size_ff;
      policy_in      = policy_ff;
      func_in        = func_ff;
      fill_frame_in  = fill_frame_ff;
      page_in        = page_ff;
      offset_in      = offset_ff;
      first_in       = first_ff;
      second_in      = second_ff;
      hit_in         = hit_ff;
      frame_in       = frame_ff;
      phys_in        = phys_ff;
      repl_in        = repl_ff;
      div_quot_in    = div_quot_ff;
      div_rem_in     = div_rem_ff;
      div_divisor_in = div_divisor_ff;
      mem_we         = 1'b0;
      mem_waddr      = idx_ff;
      mem_wtag       = rd_tag_ff;
      mem_wframe     = rd_frame_ff;

      // configuration writes
      if (csr_write_en) begin
         case (csr_index)
            CFG_PAGE_SIZE:       page_size_in = csr_wdata;
            CFG_ENTRIES_PER_TBL: ept_in       = csr_wdata[EPT_W-1:0];
            CFG_TLB_SIZE:        tlb_size_in  = csr_wdata[SIZE_W-1:0];
            CFG_REPLACE_POLICY:  policy_in    = csr_wdata[0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               func_in        = req_func;
               fill_frame_in  = req_fill_frame;
               hit_in         = 1'b0;
               frame_in       = '0;
               phys_in        = '0;
               repl_in        = 1'b0;
               div_quot_in    = req_logical_address;
               div_rem_in     = '0;
               div_divisor_in = ps_eff;
               step_in        = '0;
               state_in       = ST_DIV_PAGE;
            end
         end
         // page number and offset
         ST_DIV_PAGE: begin
            div_quot_in = div_quot_next;
            div_rem_in  = div_rem_next;
            step_in     = step_ff + STEP_W'(1);
            if (div_last) begin
               page_in        = div_quot_next;
               offset_in      = div_rem_next[OFFSET_W-1:0];
               div_quot_in    = div_quot_next;
               div_rem_in     = '0;
               div_divisor_in = PSIZE_W'(ept_eff);
               step_in        = '0;
               state_in       = ST_DIV_LEVEL;
            end
         end
         // first and second level entries, then pick the tlb action
         ST_DIV_LEVEL: begin
            div_quot_in = div_quot_next;
            div_rem_in  = div_rem_next;
            step_in     = step_ff + STEP_W'(1);
            if (div_last) begin
               first_in  = div_quot_next;
               second_in = div_rem_next[SECOND_W-1:0];
               idx_in    = '0;
               if (func_ff == FUNC_TRANSLATE) begin
                  state_in = (count_ff == '0) ? ST_DONE : ST_SEARCH;
               end else if (count_ff < CNT_W'(size_eff)) begin
                  state_in = ST_APPEND;
               end else begin
                  repl_in  = 1'b1;
                  state_in = ST_SHIFT;
               end
            end
         end
         // oldest-first search, one entry per cycle
         ST_SEARCH: begin
            if (rd_tag_ff == page_ff) begin
               hit_in   = 1'b1;
               frame_in = rd_frame_ff;
               state_in = ST_MULT;
            end else if (is_last_entry) begin
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_MULT: begin
            phys_in  = mult_prod + ADDR_W'(offset_ff);
            state_in = (policy_ff == POLICY_LRU) ? ST_SHIFT : ST_DONE;
         end
         // close the gap left by the dropped entry
         ST_SHIFT: begin
            if (can_move) begin
               mem_we    = 1'b1;
               mem_waddr = idx_ff;
               mem_wtag  = rd_tag_ff;
               mem_wframe = rd_frame_ff;
               idx_in    = idx_ff + IDX_W'(1);
            end else begin
               count_in = count_ff - CNT_W'(1);
               state_in = ST_APPEND;
            end
         end
         // write the newest entry
         ST_APPEND: begin
            if (count_ff < CNT_W'(TLB_DEPTH)) begin
               mem_we     = 1'b1;
               mem_waddr  = count_ff[IDX_W-1:0];
               mem_wtag   = page_ff;
               mem_wframe = (func_ff == FUNC_FILL) ? fill_frame_ff : frame_ff;
               count_in   = count_ff + CNT_W'(1);
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // read address: the entry after the current one while moving entries
   assign rd_addr = (state_in == ST_SHIFT) ? (idx_in + IDX_W'(1)) : idx_in;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         page_size_ff <= PAGE_SIZE_RESET;
         ept_ff       <= EPT_RESET;
         tlb_size_ff  <= TLB_SIZE_RESET;
         policy_ff    <= POLICY_FIFO;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         page_size_ff <= page_size_in;
         ept_ff       <= ept_in;
         tlb_size_ff  <= tlb_size_in;
         policy_ff    <= policy_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      step_ff        <= step_in;
      func_ff        <= func_in;
      fill_frame_ff  <= fill_frame_in;
      page_ff        <= page_in;
      offset_ff      <= offset_in;
      first_ff       <= first_in;
      second_ff      <= second_in;
      hit_ff         <= hit_in;
      frame_ff       <= frame_in;
      phys_ff        <= phys_in;
      repl_ff        <= repl_in;
      div_quot_ff    <= div_quot_in;
      div_rem_ff     <= div_rem_in;
      div_divisor_ff <= div_divisor_in;
   end

   // tag and frame store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tag_mem[mem_waddr]   <= mem_wtag;
         frame_mem[mem_waddr] <= mem_wframe;
      end
      rd_tag_ff   <= tag_mem[rd_addr];
      rd_frame_ff <= frame_mem[rd_addr];
   end

   // result ports
   assign rsp_hit                = hit_ff;
   assign rsp_frame_out          = frame_ff;
   assign rsp_physical_address   = phys_ff;
   assign rsp_first_level_entry  = first_ff;
   assign rsp_second_level_entry = second_ff;
   assign rsp_page_offset        = offset_ff;
   assign rsp_replaced           = repl_ff;

   // checks
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TLB_DEPTH))
      else $error("tlb entry count beyond depth");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request taken but block not busy");

   a_result_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!rsp_valid && !busy))
      else $error("result strobe not a single cycle before idle");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_frame_out == '0 && rsp_physical_address == '0))
      else $error("frame or address not zero without a hit");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_replaced))
      else $error("hit and eviction reported together");

endmodule

`default_nettype wire
